// ===== hw/rtl/ecv_pkg.sv =====
package ecv_pkg;

   localparam int COUNT_WIDTH_DEF = 32;
   localparam int SPEED_FRAC_DEF  = 8;

   localparam int ACTION_W   = 2;
   localparam int TIME_W     = 32;
   localparam int CSR_DATA_W = 16;
   localparam int CSR_ADDR_W = 1;
   localparam int PULSE_W    = 32;
   localparam int SPEED_W    = 24;
   localparam int Q88_SHIFT  = 8;
   localparam int PCT_W      = 7;
   localparam int DEN_W      = TIME_W + CSR_DATA_W;
   localparam int QUO_W      = SPEED_W + 1;

   localparam int REQ_DATA_W = 40;
   localparam int RSP_DATA_W = 64;
   localparam int RSP_PAD_W  = RSP_DATA_W - PULSE_W - 1 - SPEED_W;

   localparam logic [ACTION_W-1:0] ACT_ENCODER  = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_VELOCITY = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_CLEAR    = 2'd2;

   localparam logic [CSR_ADDR_W-1:0] CSR_SAMPLE_PERIOD = 1'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_FULL_SCALE    = 1'd1;

   localparam logic [CSR_DATA_W-1:0] SAMPLE_PERIOD_RST = 16'd10;
   localparam logic [CSR_DATA_W-1:0] FULL_SCALE_RST    = 16'd256;

   localparam logic [QUO_W-1:0] SPD_POS_CAP = 25'd8388607;
   localparam logic [QUO_W-1:0] SPD_NEG_CAP = 25'd8388608;

endpackage

// ===== hw/rtl/encoder_counter_with_velocity.sv =====
// Encoder and clear events go through ST_EXEC and ST_OUT from accepted word to result word.
// Velocity events that recompute go through ST_EXEC, ST_CHECK, ST_PREP, ST_DIV, ST_FIN and ST_OUT;
//   ST_DIV runs the restoring divider that retires one quotient bit per cycle.
// Velocity events below the sample period go through ST_EXEC and ST_CHECK to ST_OUT.
// A new word is taken once the result is in the output register; that register holds it until taken.
// Reset is synchronous: counters, velocity and sample reference clear, registers go to defaults.
module encoder_counter_with_velocity #(
   parameter int COUNT_WIDTH         = ecv_pkg::COUNT_WIDTH_DEF,
   parameter int SPEED_FRACTION_BITS = ecv_pkg::SPEED_FRAC_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // action
   input  logic [ecv_pkg::ACTION_W-1:0]        req_tuser,
   // level_a, level_b, time_ms[31:0], zero pad
   input  logic [ecv_pkg::REQ_DATA_W-1:0]      req_tdata,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // pulse_count[31:0], direction, velocity[23:0], zero pad
   output logic [ecv_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   // velocity_updated
   output logic                                rsp_tuser,
   input  logic                                csr_wen,
   input  logic [ecv_pkg::CSR_ADDR_W-1:0]      csr_addr,
   input  logic [ecv_pkg::CSR_DATA_W-1:0]      csr_wdata
);
   import ecv_pkg::*;

   localparam int SHIFT    = Q88_SHIFT + SPEED_FRACTION_BITS;
   localparam int MAG100_W = COUNT_WIDTH + PCT_W;
   localparam int NUM_W    = MAG100_W + SHIFT;
   localparam int CNT_W    = $clog2(NUM_W + 1);

   typedef enum logic [2:0] {
      ST_IDLE, ST_EXEC, ST_CHECK, ST_PREP, ST_DIV, ST_FIN, ST_OUT
   } state_type;

   state_type                 state_ff;
   logic [ACTION_W-1:0]       action_ff;
   logic                      level_a_ff, level_b_ff;
   logic [TIME_W-1:0]         time_ff;

   logic [CSR_DATA_W-1:0]     period_ff, fsr_ff;
   logic [COUNT_WIDTH-1:0]    count_ff, count_at_sample_ff;
   logic                      forward_ff, last_a_ff;
   logic [TIME_W-1:0]         time_at_sample_ff;
   logic [SPEED_W-1:0]        speed_ff;
   logic                      updated_ff;

   logic [TIME_W-1:0]         elapsed_ff;
   logic [COUNT_WIDTH-1:0]    diff_ff, mag_ff;
   logic                      neg_ff;
   logic [DEN_W-1:0]          den_ff, rem_ff;
   logic [NUM_W-1:0]          num_ff;
   logic [QUO_W-1:0]          q_ff;
   logic                      ovf_ff;
   logic [CNT_W-1:0]          bit_cnt_ff;

   logic                      rsp_tvalid_ff;
   logic [RSP_DATA_W-1:0]     rsp_tdata_ff;
   logic                      rsp_tuser_ff;

   logic [CSR_DATA_W-1:0]     period_eff, fsr_eff;
   logic                      fwd_in;
   logic [MAG100_W-1:0]       mag_ext, mag100_in;
   logic [DEN_W:0]            rem_sh, rem_sub;
   logic                      rem_ge;
   logic [QUO_W-1:0]          cap;
   logic                      big;
   logic [SPEED_W-1:0]        speed_mag, speed_in;
   logic                      out_free;

   assign period_eff = (period_ff == '0) ? CSR_DATA_W'(1) : period_ff;
   assign fsr_eff    = (fsr_ff == '0) ? CSR_DATA_W'(1) : fsr_ff;
   assign fwd_in     = (!last_a_ff && level_a_ff) ? level_b_ff : forward_ff;

   // x100 = x64 + x32 + x4
   assign mag_ext   = MAG100_W'(mag_ff);
   assign mag100_in = (mag_ext << 6) + (mag_ext << 5) + (mag_ext << 2);

   assign rem_sh  = {rem_ff, num_ff[NUM_W-1]};
   assign rem_ge  = rem_sh >= {1'b0, den_ff};
   assign rem_sub = rem_sh - {1'b0, den_ff};

   assign cap       = neg_ff ? SPD_NEG_CAP : SPD_POS_CAP;
   assign big       = ovf_ff || (q_ff > cap);
   assign speed_mag = big ? cap[SPEED_W-1:0] : q_ff[SPEED_W-1:0];
   assign speed_in  = neg_ff ? SPEED_W'(0) - speed_mag : speed_mag;

   assign out_free   = !rsp_tvalid_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tuser  = rsp_tuser_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff <= SAMPLE_PERIOD_RST;
         fsr_ff    <= FULL_SCALE_RST;
      end else if (csr_wen) begin
         unique case (csr_addr)
            CSR_SAMPLE_PERIOD: period_ff <= csr_wdata;
            CSR_FULL_SCALE:    fsr_ff    <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff           <= ST_IDLE;
         count_ff           <= '0;
         count_at_sample_ff <= '0;
         forward_ff         <= 1'b0;
         last_a_ff          <= 1'b0;
         time_at_sample_ff  <= '0;
         speed_ff           <= '0;
         updated_ff         <= 1'b0;
         rsp_tvalid_ff      <= 1'b0;
      end else begin
         if (rsp_tvalid_ff && rsp_tready && state_ff != ST_OUT) begin
            rsp_tvalid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (req_tvalid) begin
                  action_ff  <= req_tuser;
                  level_a_ff <= req_tdata[0];
                  level_b_ff <= req_tdata[1];
                  time_ff    <= req_tdata[TIME_W+1:2];
                  state_ff   <= ST_EXEC;
               end
            end
            ST_EXEC: begin
               updated_ff <= 1'b0;
               state_ff   <= ST_OUT;
               case (action_ff)
                  ACT_ENCODER: begin
                     forward_ff <= fwd_in;
                     last_a_ff  <= level_a_ff;
                     count_ff   <= fwd_in ? count_ff + COUNT_WIDTH'(1)
                                          : count_ff - COUNT_WIDTH'(1);
                  end
                  ACT_VELOCITY: begin
                     elapsed_ff <= time_ff - time_at_sample_ff;
                     diff_ff    <= count_ff - count_at_sample_ff;
                     state_ff   <= ST_CHECK;
                  end
                  ACT_CLEAR: count_ff <= '0;
                  default: ;
               endcase
            end
            ST_CHECK: begin
               if (elapsed_ff >= TIME_W'(period_eff)) begin
                  den_ff             <= DEN_W'(elapsed_ff) * DEN_W'(fsr_eff);
                  neg_ff             <= diff_ff[COUNT_WIDTH-1];
                  mag_ff             <= diff_ff[COUNT_WIDTH-1] ? '0 - diff_ff : diff_ff;
                  count_at_sample_ff <= count_ff;
                  time_at_sample_ff  <= time_ff;
                  state_ff           <= ST_PREP;
               end else begin
                  state_ff <= ST_OUT;
               end
            end
            ST_PREP: begin
               num_ff     <= {mag100_in, {SHIFT{1'b0}}};
               rem_ff     <= '0;
               q_ff       <= '0;
               ovf_ff     <= 1'b0;
               bit_cnt_ff <= CNT_W'(NUM_W);
               state_ff   <= ST_DIV;
            end
            ST_DIV: begin
               rem_ff     <= rem_ge ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
               q_ff       <= {q_ff[QUO_W-2:0], rem_ge};
               ovf_ff     <= ovf_ff | q_ff[QUO_W-1];
               num_ff     <= num_ff << 1;
               bit_cnt_ff <= bit_cnt_ff - CNT_W'(1);
               if (bit_cnt_ff == CNT_W'(1)) begin
                  state_ff <= ST_FIN;
               end
            end
            ST_FIN: begin
               speed_ff   <= speed_in;
               updated_ff <= 1'b1;
               state_ff   <= ST_OUT;
            end
            ST_OUT: begin
               if (out_free) begin
                  rsp_tvalid_ff <= 1'b1;
                  rsp_tdata_ff  <= {{RSP_PAD_W{1'b0}}, speed_ff, forward_ff,
                                    PULSE_W'(count_ff)};
                  rsp_tuser_ff  <= updated_ff;
                  state_ff      <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> state_ff == ST_EXEC)
      else $error("accepted word did not start execution");

   a_div_count: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DIV |-> bit_cnt_ff != '0)
      else $error("divider ran past its last bit");

   a_div_den: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DIV |-> den_ff != '0 && rem_ff < den_ff)
      else $error("divider remainder out of range");

   a_out_load: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_OUT && out_free |=> rsp_tvalid_ff && state_ff == ST_IDLE)
      else $error("result word not loaded");

endmodule

// ===== sim/encoder_counter_with_velocity_tb.sv =====
module encoder_counter_with_velocity_tb;
   import ecv_pkg::*;

   localparam logic [ACTION_W-1:0] ACT_RESERVED = 2'd3;
   localparam int SPEED_SHIFT   = Q88_SHIFT + SPEED_FRAC_DEF;
   localparam int ITEMS_PER_RUN = 220;
   localparam int NUM_RUNS      = 6;
   localparam int HOLD_CYCLES   = 300;
   localparam int SETTLE_CYCLES = 80;

   typedef struct packed {
      logic [PULSE_W-1:0] pulse_count;
      logic               direction;
      logic [SPEED_W-1:0] velocity;
      logic               updated;
   } reading_type;

   typedef struct {
      bit                     on;
      reading_type            r;
   } pin_type;

   typedef struct {
      bit                     is_csr;
      logic [CSR_ADDR_W-1:0]  reg_idx;
      logic [CSR_DATA_W-1:0]  reg_val;
      logic [ACTION_W-1:0]    action;
      logic                   lvl_a;
      logic                   lvl_b;
      logic [TIME_W-1:0]      t_ms;
      pin_type                pin;
   } plan_row_type;

   logic                   clock;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [ACTION_W-1:0]    req_tuser;
   logic [REQ_DATA_W-1:0]  req_tdata;
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   logic [RSP_DATA_W-1:0]  rsp_tdata;
   logic                   rsp_tuser;
   logic                   csr_wen;
   logic [CSR_ADDR_W-1:0]  csr_addr;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   encoder_counter_with_velocity uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_wen    (csr_wen),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   logic [CSR_DATA_W-1:0] cfg_period     = SAMPLE_PERIOD_RST;
   logic [CSR_DATA_W-1:0] cfg_full_scale = FULL_SCALE_RST;
   logic [PULSE_W-1:0]    enc_count      = '0;
   logic                  enc_forward    = 1'b0;
   logic                  enc_prev_a     = 1'b0;
   logic [PULSE_W-1:0]    ref_count      = '0;
   logic [TIME_W-1:0]     ref_ms         = '0;
   logic [SPEED_W-1:0]    speed_q        = '0;

   reading_type  readings_due[$];
   pin_type      pins_due[$];
   plan_row_type plan[$];
   int        fail_count  = 0;
   int        tx_idle_pct = 0;
   int        rx_idle_pct = 0;
   int        hold_len    = 0;

   logic [1:0]        quad_pos = 2'd0;
   logic              gen_dir  = 1'b1;
   logic [TIME_W-1:0] gen_ms   = '0;

   function automatic reading_type next_reading(input logic [ACTION_W-1:0] act,
                                                input logic lvl_a, input logic lvl_b,
                                                input logic [TIME_W-1:0] t_ms);
      reading_type       r;
      logic [TIME_W-1:0] elapsed;
      logic [TIME_W-1:0] period_eff;
      logic [PULSE_W-1:0] diff;
      logic [PULSE_W-1:0] mag32;
      logic [63:0]       mag64;
      logic [63:0]       el64;
      logic [63:0]       fs64;
      logic [63:0]       quo;
      logic              neg;
      logic              upd;
      upd = 1'b0;
      case (act)
         ACT_ENCODER: begin
            if (!enc_prev_a && lvl_a) enc_forward = lvl_b;
            enc_prev_a = lvl_a;
            enc_count = enc_forward ? enc_count + PULSE_W'(1) : enc_count - PULSE_W'(1);
         end
         ACT_VELOCITY: begin
            elapsed = t_ms - ref_ms;
            period_eff = (cfg_period == '0) ? 32'd1 : {16'd0, cfg_period};
            if (elapsed >= period_eff) begin
               diff = enc_count - ref_count;
               neg = diff[PULSE_W-1];
               mag32 = neg ? (~diff + PULSE_W'(1)) : diff;
               mag64 = {32'd0, mag32};
               el64 = {32'd0, elapsed};
               fs64 = (cfg_full_scale == '0) ? 64'd1 : {48'd0, cfg_full_scale};
               quo = ((mag64 * 64'd100) << SPEED_SHIFT) / (el64 * fs64);
               if (neg) begin
                  if (quo > {39'd0, SPD_NEG_CAP}) quo = {39'd0, SPD_NEG_CAP};
                  quo = 64'd0 - quo;
               end else if (quo > {39'd0, SPD_POS_CAP}) begin
                  quo = {39'd0, SPD_POS_CAP};
               end
               speed_q = quo[SPEED_W-1:0];
               ref_count = enc_count;
               ref_ms = t_ms;
               upd = 1'b1;
            end
         end
         ACT_CLEAR: enc_count = '0;
         default: ;
      endcase
      r.pulse_count = enc_count;
      r.direction = enc_forward;
      r.velocity = speed_q;
      r.updated = upd;
      return r;
   endfunction

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #4000000;
      $display("CHECKS FAILED");
      $finish;
   end

   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_len > 0) begin
            rsp_tready = 1'b0;
            hold_len = hold_len - 1;
         end else begin
            rsp_tready = ($urandom_range(0, 99) >= rx_idle_pct);
         end
      end
   end

   always @(posedge clock) begin
      reading_type r;
      reading_type got;
      pin_type     p;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            r = next_reading(req_tuser, req_tdata[0], req_tdata[1], req_tdata[2 +: TIME_W]);
            p.on = 1'b0;
            if (pins_due.size() != 0) p = pins_due.pop_front();
            readings_due.push_back(p.on ? p.r : r);
         end
         if (rsp_tvalid && rsp_tready) begin
            got.pulse_count = rsp_tdata[0 +: PULSE_W];
            got.direction = rsp_tdata[PULSE_W];
            got.velocity = rsp_tdata[PULSE_W + 1 +: SPEED_W];
            got.updated = rsp_tuser;
            if (readings_due.size() == 0) begin
               $display("%0t: unexpected word, got count %h dir %b vel %h upd %b", $time,
                        got.pulse_count, got.direction, got.velocity, got.updated);
               fail_count++;
            end else begin
               r = readings_due.pop_front();
               if (got !== r) begin
                  $display("%0t: expected count %h dir %b vel %h upd %b, got %h %b %h %b",
                           $time, r.pulse_count, r.direction, r.velocity, r.updated,
                           got.pulse_count, got.direction, got.velocity, got.updated);
                  fail_count++;
               end
            end
         end
      end
   end

   task automatic drain();
      @(negedge clock);
      req_tvalid = 1'b0;
      while (readings_due.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_ADDR_W-1:0] idx, input logic [CSR_DATA_W-1:0] val);
      drain();
      @(negedge clock);
      csr_wen = 1'b1;
      csr_addr = idx;
      csr_wdata = val;
      @(posedge clock);
      if (idx == CSR_SAMPLE_PERIOD) cfg_period = val;
      else cfg_full_scale = val;
      @(negedge clock);
      csr_wen = 1'b0;
   endtask

   task automatic send_word(input logic [ACTION_W-1:0] act, input logic lvl_a,
                            input logic lvl_b, input logic [TIME_W-1:0] t_ms,
                            input pin_type pin);
      @(negedge clock);
      while ($urandom_range(0, 99) < tx_idle_pct) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      pins_due.push_back(pin);
      req_tuser = act;
      req_tdata = {6'd0, t_ms, lvl_b, lvl_a};
      req_tvalid = 1'b1;
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic plan_word(input logic [ACTION_W-1:0] act, input logic lvl_a,
                            input logic lvl_b, input logic [TIME_W-1:0] t_ms);
      plan_row_type row;
      row = '{default: '0};
      row.action = act;
      row.lvl_a = lvl_a;
      row.lvl_b = lvl_b;
      row.t_ms = t_ms;
      plan.push_back(row);
   endtask

   task automatic plan_pinned(input logic [ACTION_W-1:0] act, input logic lvl_a,
                              input logic lvl_b, input logic [TIME_W-1:0] t_ms,
                              input logic [PULSE_W-1:0] cnt, input logic dir,
                              input logic [SPEED_W-1:0] vel, input logic upd);
      plan_word(act, lvl_a, lvl_b, t_ms);
      plan[$].pin.on = 1'b1;
      plan[$].pin.r = '{cnt, dir, vel, upd};
   endtask

   task automatic plan_reg(input logic [CSR_ADDR_W-1:0] idx, input logic [CSR_DATA_W-1:0] val);
      plan_row_type row;
      row = '{default: '0};
      row.is_csr = 1'b1;
      row.reg_idx = idx;
      row.reg_val = val;
      plan.push_back(row);
   endtask

   task automatic send_random();
      logic [ACTION_W-1:0] act;
      logic                lvl_a;
      logic                lvl_b;
      logic [TIME_W-1:0]   t_ms;
      logic [TIME_W-1:0]   period_eff;
      int                  pick;
      pin_type             nopin;
      nopin = '{default: '0};
      pick = $urandom_range(0, 99);
      lvl_a = 1'($urandom_range(0, 1));
      lvl_b = 1'($urandom_range(0, 1));
      t_ms = $urandom;
      if (pick < 58) begin
         act = ACT_ENCODER;
         if ($urandom_range(0, 99) >= 12) begin
            if ($urandom_range(0, 99) < 6) gen_dir = !gen_dir;
            quad_pos = gen_dir ? quad_pos + 2'd1 : quad_pos - 2'd1;
            lvl_a = quad_pos[1];
            lvl_b = quad_pos[1] ^ quad_pos[0];
         end
      end else if (pick < 88) begin
         act = ACT_VELOCITY;
         period_eff = (cfg_period == '0) ? 32'd1 : {16'd0, cfg_period};
         if ($urandom_range(0, 99) < 8) gen_ms = $urandom;
         else gen_ms = gen_ms + $urandom_range(0, 2 * period_eff);
         t_ms = gen_ms;
      end else if (pick < 94) begin
         act = ACT_CLEAR;
      end else begin
         act = ACT_RESERVED;
      end
      send_word(act, lvl_a, lvl_b, t_ms, nopin);
   endtask

   initial begin
      logic [CSR_DATA_W-1:0] run_period[NUM_RUNS];
      logic [CSR_DATA_W-1:0] run_scale[NUM_RUNS];
      plan_row_type          row;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tuser = '0;
      req_tdata = '0;
      csr_wen = 1'b0;
      csr_addr = '0;
      csr_wdata = '0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      plan_pinned(ACT_RESERVED, 1'b1, 1'b1, 32'hFFFF_FFFF, 32'd0, 1'b0, 24'd0, 1'b0);
      plan_pinned(ACT_VELOCITY, 1'b1, 1'b1, 32'd9, 32'd0, 1'b0, 24'd0, 1'b0);
      plan_pinned(ACT_CLEAR, 1'b1, 1'b1, 32'hFFFF_FFFF, 32'd0, 1'b0, 24'd0, 1'b0);
      plan_pinned(ACT_ENCODER, 1'b1, 1'b1, 32'd0, 32'd1, 1'b1, 24'd0, 1'b0);
      plan_pinned(ACT_ENCODER, 1'b1, 1'b0, 32'hFFFF_FFFF, 32'd2, 1'b1, 24'd0, 1'b0);
      plan_pinned(ACT_ENCODER, 1'b0, 1'b0, 32'd0, 32'd3, 1'b1, 24'd0, 1'b0);
      plan_word(ACT_VELOCITY, 1'b0, 1'b0, 32'd10);
      plan_word(ACT_ENCODER, 1'b1, 1'b0, 32'd0);
      plan_word(ACT_ENCODER, 1'b0, 1'b1, 32'd0);
      plan_word(ACT_CLEAR, 1'b0, 1'b0, 32'd0);
      plan_word(ACT_VELOCITY, 1'b1, 1'b0, 32'hFFFF_FFFF);
      plan_word(ACT_VELOCITY, 1'b0, 1'b0, 32'd20);
      plan_reg(CSR_SAMPLE_PERIOD, 16'd0);
      plan_reg(CSR_FULL_SCALE, 16'd0);
      plan_pinned(ACT_VELOCITY, 1'b0, 1'b0, 32'd20, 32'd0, 1'b0, 24'd0, 1'b0);
      plan_pinned(ACT_ENCODER, 1'b0, 1'b1, 32'd0, 32'hFFFF_FFFF, 1'b0, 24'd0, 1'b0);
      plan_pinned(ACT_ENCODER, 1'b0, 1'b0, 32'd0, 32'hFFFF_FFFE, 1'b0, 24'd0, 1'b0);
      plan_pinned(ACT_VELOCITY, 1'b0, 1'b0, 32'd21, 32'hFFFF_FFFE, 1'b0, 24'h800000, 1'b1);
      plan_word(ACT_ENCODER, 1'b1, 1'b1, 32'd0);
      plan_word(ACT_ENCODER, 1'b1, 1'b1, 32'd0);
      plan_pinned(ACT_VELOCITY, 1'b0, 1'b0, 32'd22, 32'd0, 1'b1, 24'h7FFFFF, 1'b1);
      plan_word(ACT_ENCODER, 1'b0, 1'b0, 32'd0);
      plan_word(ACT_VELOCITY, 1'b0, 1'b0, 32'd23);
      plan_reg(CSR_SAMPLE_PERIOD, 16'hFFFF);
      plan_reg(CSR_FULL_SCALE, 16'hFFFF);
      plan_word(ACT_VELOCITY, 1'b0, 1'b0, 32'd65557);
      plan_word(ACT_VELOCITY, 1'b0, 1'b0, 32'd65558);
      plan_word(ACT_CLEAR, 1'b0, 1'b0, 32'd0);
      plan_word(ACT_VELOCITY, 1'b0, 1'b0, 32'd131093);

      tx_idle_pct = 27;
      rx_idle_pct = 53;
      foreach (plan[i]) begin
         row = plan[i];
         if (row.is_csr) write_reg(row.reg_idx, row.reg_val);
         else send_word(row.action, row.lvl_a, row.lvl_b, row.t_ms, row.pin);
      end

      run_period = '{16'd10, 16'd1, 16'hFFFF, 16'd0, 16'd0, 16'd0};
      run_scale = '{16'd256, 16'd1, 16'hFFFF, 16'd0, 16'd0, 16'd0};
      run_period[4] = CSR_DATA_W'($urandom_range(1, 40));
      run_scale[4] = CSR_DATA_W'($urandom_range(1, 65535));
      run_period[5] = CSR_DATA_W'($urandom_range(0, 65535));
      run_scale[5] = CSR_DATA_W'($urandom_range(0, 65535));

      for (int run = 0; run < NUM_RUNS; run++) begin
         write_reg(CSR_SAMPLE_PERIOD, run_period[run]);
         write_reg(CSR_FULL_SCALE, run_scale[run]);
         gen_ms = ref_ms;
         case (run / 2)
            0: begin
               tx_idle_pct = 27;
               rx_idle_pct = 53;
            end
            1: begin
               tx_idle_pct = 53;
               rx_idle_pct = 27;
            end
            default: begin
               tx_idle_pct = 0;
               rx_idle_pct = 0;
            end
         endcase
         if (run == 1 || run == 3) hold_len = HOLD_CYCLES;
         for (int n = 0; n < ITEMS_PER_RUN; n++) send_random();
         drain();
      end

      repeat (SETTLE_CYCLES) @(posedge clock);
      if (fail_count == 0 && readings_due.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

// ===== encoder_counter_with_velocity.f =====
hw/rtl/ecv_pkg.sv
hw/rtl/encoder_counter_with_velocity.sv
sim/encoder_counter_with_velocity_tb.sv
